[design/pulse_period_power_meter_macros.svh]
// Assertion macros for the pulse period power meter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef PULSE_PERIOD_POWER_METER_MACROS_SVH
`define PULSE_PERIOD_POWER_METER_MACROS_SVH

// same-cycle implication
`define PPPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pppm check failed");

// next-cycle implication
`define PPPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pppm check failed");

`endif

[design/pppm_pkg.sv]
// Shared widths, codes and reset values of the pulse period power meter.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package pppm_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned PERIOD_W  = 31;
   localparam int unsigned PF_W      = 17;
   localparam int unsigned ACTION_W  = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned DVD_W     = DATA_W + FRAC_W;
   localparam int unsigned CNT_W     = 6;

   typedef logic [ACTION_W-1:0]  action_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam action_type ACT_POWER  = 2'd0;
   localparam action_type ACT_SHARED = 2'd1;
   localparam action_type ACT_READ   = 2'd2;

   localparam csr_idx_type REG_CUR_MULT  = 3'd0;
   localparam csr_idx_type REG_VOLT_MULT = 3'd1;
   localparam csr_idx_type REG_POW_MULT  = 3'd2;
   localparam csr_idx_type REG_MODE      = 3'd3;
   localparam csr_idx_type REG_TIMEOUT   = 3'd4;

   localparam logic MODE_VOLTAGE = 1'b1;
   localparam logic MODE_RESET   = MODE_VOLTAGE;

   localparam logic [PERIOD_W-1:0] TIMEOUT_RESET = 31'd2000000;
   localparam logic [PF_W-1:0]     PF_ONE        = 17'h10000;

   localparam logic [CNT_W-1:0] DIV_STEPS_Q  = CNT_W'(DATA_W);
   localparam logic [CNT_W-1:0] DIV_STEPS_PF = CNT_W'(DVD_W);
   localparam logic [CNT_W-1:0] MUL_STEPS    = CNT_W'(DATA_W);

endpackage

[design/pulse_period_power_meter.sv]
// Pulse period power meter: edge period capture and serial read-out arithmetic; uses pppm_pkg.
// Edge transaction: subtract, then timeout check in S_CHECK; next item taken back in S_IDLE.
// Read transaction: current, voltage and active power divisions, a multiply, a compare,
// power factor division; one shared radix-2 divider, shift-add multiplier, one bit per cycle.
// A finished result waits in the output register while edge transactions go on.
// Synchronous reset: multipliers, edge times, periods, state cleared; mode, timeout preset.
`timescale 1ns / 1ps

module pulse_period_power_meter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pppm_pkg::ACTION_W-1:0] req_action,
   input  logic [pppm_pkg::DATA_W-1:0]   req_timestamp,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pppm_pkg::DATA_W-1:0]   rsp_current_value,
   output logic [pppm_pkg::DATA_W-1:0]   rsp_voltage_value,
   output logic [pppm_pkg::DATA_W-1:0]   rsp_active_power,
   output logic [pppm_pkg::DATA_W-1:0]   rsp_apparent_power,
   output logic [pppm_pkg::PF_W-1:0]     rsp_power_factor,
   input  logic                          csr_write,
   input  logic [pppm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pppm_pkg::DATA_W-1:0]   csr_wdata
);
   import pppm_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_LOAD  = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_CMP   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      OP_CUR  = 2'd0,
      OP_VOLT = 2'd1,
      OP_ACT  = 2'd2,
      OP_PF   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CH_POWER   = 2'd0,
      CH_CURRENT = 2'd1,
      CH_VOLTAGE = 2'd2
   } chan_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   chan_type  chan_ff, chan_in;

   logic [DATA_W-1:0]   cur_mult_ff, cur_mult_in;
   logic [DATA_W-1:0]   volt_mult_ff, volt_mult_in;
   logic [DATA_W-1:0]   pow_mult_ff, pow_mult_in;
   logic                mode_ff, mode_in;
   logic [PERIOD_W-1:0] timeout_ff, timeout_in;

   logic [DATA_W-1:0]   last_pow_ff, last_pow_in;
   logic [DATA_W-1:0]   last_cur_ff, last_cur_in;
   logic [DATA_W-1:0]   last_volt_ff, last_volt_in;
   logic [PERIOD_W-1:0] pow_per_ff, pow_per_in;
   logic [PERIOD_W-1:0] cur_per_ff, cur_per_in;
   logic [PERIOD_W-1:0] volt_per_ff, volt_per_in;

   logic [DATA_W-1:0]   diff_ff, diff_in;
   logic [DATA_W-1:0]   cur_ff, cur_in;
   logic [DATA_W-1:0]   volt_ff, volt_in;
   logic [DATA_W-1:0]   actp_ff, actp_in;
   logic [DATA_W-1:0]   app_ff, app_in;
   logic [PF_W-1:0]     pf_ff, pf_in;

   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   dvs_ff, dvs_in;
   logic                dz_ff, dz_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [2*DATA_W-1:0] mul_ff, mul_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_cur_ff, rsp_cur_in;
   logic [DATA_W-1:0]   rsp_volt_ff, rsp_volt_in;
   logic [DATA_W-1:0]   rsp_act_ff, rsp_act_in;
   logic [DATA_W-1:0]   rsp_app_ff, rsp_app_in;
   logic [PF_W-1:0]     rsp_pf_ff, rsp_pf_in;

   // divider and multiplier step, period check, output free
   logic [DATA_W:0]     div_shift;
   logic [DATA_W:0]     div_trial;
   logic                div_qbit;
   logic [DVD_W-1:0]    div_quot;
   logic [DATA_W-1:0]   div_result;
   logic [DATA_W:0]     mul_sum;
   logic [2*DATA_W-1:0] mul_next;
   logic [PERIOD_W-1:0] period_meas;
   logic                out_free;

   assign div_shift  = {rem_ff, dvd_ff[DVD_W-1]};
   assign div_trial  = div_shift - {1'b0, dvs_ff};
   assign div_qbit   = ~div_trial[DATA_W];
   assign div_quot   = {dvd_ff[DVD_W-2:0], div_qbit};
   assign div_result = dz_ff ? '0 : div_quot[DATA_W-1:0];

   assign mul_sum  = {1'b0, mul_ff[2*DATA_W-1:DATA_W]}
                   + (mul_ff[0] ? {1'b0, volt_ff} : {(DATA_W+1){1'b0}});
   assign mul_next = {mul_sum, mul_ff[DATA_W-1:1]};

   assign period_meas = (diff_ff[DATA_W-1] || (diff_ff[PERIOD_W-1:0] > timeout_ff))
                      ? '0 : diff_ff[PERIOD_W-1:0];

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      chan_in      = chan_ff;
      cur_mult_in  = cur_mult_ff;
      volt_mult_in = volt_mult_ff;
      pow_mult_in  = pow_mult_ff;
      mode_in      = mode_ff;
      timeout_in   = timeout_ff;
      last_pow_in  = last_pow_ff;
      last_cur_in  = last_cur_ff;
      last_volt_in = last_volt_ff;
      pow_per_in   = pow_per_ff;
      cur_per_in   = cur_per_ff;
      volt_per_in  = volt_per_ff;
      diff_in      = diff_ff;
      cur_in       = cur_ff;
      volt_in      = volt_ff;
      actp_in      = actp_ff;
      app_in       = app_ff;
      pf_in        = pf_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      dz_in        = dz_ff;
      cnt_in       = cnt_ff;
      mul_in       = mul_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_cur_in   = rsp_cur_ff;
      rsp_volt_in  = rsp_volt_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_app_in   = rsp_app_ff;
      rsp_pf_in    = rsp_pf_ff;

      if (csr_write) begin
         unique case (csr_index)
            REG_CUR_MULT:  cur_mult_in  = csr_wdata;
            REG_VOLT_MULT: volt_mult_in = csr_wdata;
            REG_POW_MULT:  pow_mult_in  = csr_wdata;
            REG_MODE:      mode_in      = csr_wdata[0];
            REG_TIMEOUT:   timeout_in   = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  ACT_POWER: begin
                     diff_in     = req_timestamp - last_pow_ff;
                     last_pow_in = req_timestamp;
                     chan_in     = CH_POWER;
                     state_in    = S_CHECK;
                  end
                  ACT_SHARED: begin
                     if (mode_ff == MODE_VOLTAGE) begin
                        diff_in      = req_timestamp - last_volt_ff;
                        last_volt_in = req_timestamp;
                        chan_in      = CH_VOLTAGE;
                     end else begin
                        diff_in      = req_timestamp - last_cur_ff;
                        last_cur_in  = req_timestamp;
                        chan_in      = CH_CURRENT;
                     end
                     state_in = S_CHECK;
                  end
                  ACT_READ: begin
                     op_in    = OP_CUR;
                     state_in = S_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            unique case (chan_ff)
               CH_POWER:   pow_per_in  = period_meas;
               CH_CURRENT: cur_per_in  = period_meas;
               CH_VOLTAGE: volt_per_in = period_meas;
               default: ;
            endcase
            state_in = S_IDLE;
         end
         S_LOAD: begin
            rem_in = '0;
            cnt_in = DIV_STEPS_Q;
            unique case (op_ff)
               OP_CUR: begin
                  dvd_in = {cur_mult_ff, {FRAC_W{1'b0}}};
                  dvs_in = {1'b0, cur_per_ff};
                  dz_in  = (cur_per_ff == '0) || (pow_per_ff == '0);
               end
               OP_VOLT: begin
                  dvd_in = {volt_mult_ff, {FRAC_W{1'b0}}};
                  dvs_in = {1'b0, volt_per_ff};
                  dz_in  = (volt_per_ff == '0);
               end
               OP_ACT: begin
                  dvd_in = {pow_mult_ff, {FRAC_W{1'b0}}};
                  dvs_in = {1'b0, pow_per_ff};
                  dz_in  = (pow_per_ff == '0);
               end
               OP_PF: begin
                  dvd_in = {actp_ff, {FRAC_W{1'b0}}};
                  dvs_in = app_ff;
                  dz_in  = 1'b0;
                  cnt_in = DIV_STEPS_PF;
               end
               default: ;
            endcase
            state_in = S_DIV;
         end
         S_DIV: begin
            dvd_in = div_quot;
            rem_in = div_qbit ? div_trial[DATA_W-1:0] : div_shift[DATA_W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               unique case (op_ff)
                  OP_CUR: begin
                     cur_in   = div_result;
                     op_in    = OP_VOLT;
                     state_in = S_LOAD;
                  end
                  OP_VOLT: begin
                     volt_in  = div_result;
                     op_in    = OP_ACT;
                     state_in = S_LOAD;
                  end
                  OP_ACT: begin
                     actp_in  = div_result;
                     mul_in   = {{DATA_W{1'b0}}, cur_ff};
                     cnt_in   = MUL_STEPS;
                     state_in = S_MUL;
                  end
                  OP_PF: begin
                     pf_in    = div_quot[PF_W-1:0];
                     state_in = S_DONE;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            mul_in = mul_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               app_in   = (|mul_next[2*DATA_W-1:DATA_W]) ? '1 : mul_next[DATA_W-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            priority if (actp_ff > app_ff) begin
               pf_in    = PF_ONE;
               state_in = S_DONE;
            end else if (app_ff == '0) begin
               pf_in    = '0;
               state_in = S_DONE;
            end else begin
               op_in    = OP_PF;
               state_in = S_LOAD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cur_in   = cur_ff;
               rsp_volt_in  = volt_ff;
               rsp_act_in   = actp_ff;
               rsp_app_in   = app_ff;
               rsp_pf_in    = pf_ff;
               pow_per_in   = '0;
               cur_per_in   = '0;
               volt_per_in  = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_mult_ff  <= '0;
         volt_mult_ff <= '0;
         pow_mult_ff  <= '0;
         mode_ff      <= MODE_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         last_pow_ff  <= '0;
         last_cur_ff  <= '0;
         last_volt_ff <= '0;
         pow_per_ff   <= '0;
         cur_per_ff   <= '0;
         volt_per_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_mult_ff  <= cur_mult_in;
         volt_mult_ff <= volt_mult_in;
         pow_mult_ff  <= pow_mult_in;
         mode_ff      <= mode_in;
         timeout_ff   <= timeout_in;
         last_pow_ff  <= last_pow_in;
         last_cur_ff  <= last_cur_in;
         last_volt_ff <= last_volt_in;
         pow_per_ff   <= pow_per_in;
         cur_per_ff   <= cur_per_in;
         volt_per_ff  <= volt_per_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      chan_ff     <= chan_in;
      diff_ff     <= diff_in;
      cur_ff      <= cur_in;
      volt_ff     <= volt_in;
      actp_ff     <= actp_in;
      app_ff      <= app_in;
      pf_ff       <= pf_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      dz_ff       <= dz_in;
      cnt_ff      <= cnt_in;
      mul_ff      <= mul_in;
      rsp_cur_ff  <= rsp_cur_in;
      rsp_volt_ff <= rsp_volt_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_app_ff  <= rsp_app_in;
      rsp_pf_ff   <= rsp_pf_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_value  = rsp_cur_ff;
   assign rsp_voltage_value  = rsp_volt_ff;
   assign rsp_active_power   = rsp_act_ff;
   assign rsp_apparent_power = rsp_app_ff;
   assign rsp_power_factor   = rsp_pf_ff;

endmodule

[design/pppm_checker.sv]
// Port-level checks of the pulse period power meter, bound to the top level.
// Depends on pppm_pkg and pulse_period_power_meter_macros.svh.
`timescale 1ns / 1ps
`include "pulse_period_power_meter_macros.svh"

module pppm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [pppm_pkg::ACTION_W-1:0] req_action,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [pppm_pkg::DATA_W-1:0]   rsp_current_value,
   input logic [pppm_pkg::DATA_W-1:0]   rsp_voltage_value,
   input logic [pppm_pkg::DATA_W-1:0]   rsp_active_power,
   input logic [pppm_pkg::DATA_W-1:0]   rsp_apparent_power,
   input logic [pppm_pkg::PF_W-1:0]     rsp_power_factor
);
   import pppm_pkg::*;

   // stalled result holds
   `PPPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_current_value) && $stable(rsp_voltage_value) && $stable(rsp_active_power) && $stable(rsp_apparent_power) && $stable(rsp_power_factor))

   // a read transaction keeps the block busy
   `PPPM_ASSERT_NEXT(a_read_busy, clock, reset, req_valid && !req_stall && (req_action == ACT_READ), req_stall)

   `PPPM_ASSERT_NOW(a_pf_full, clock, reset, rsp_valid && (rsp_active_power > rsp_apparent_power), rsp_power_factor == PF_ONE)

   `PPPM_ASSERT_NOW(a_app_zero, clock, reset, rsp_valid && ((rsp_current_value == '0) || (rsp_voltage_value == '0)), rsp_apparent_power == '0)

endmodule

bind pulse_period_power_meter pppm_checker u_pppm_checker (.*);

[tb/pulse_period_power_meter_tb.sv]
// Self-checking testbench for the pulse period power meter: directed and random
// edge/read transactions, checked against an in-bench model of periods and readings.
// Depends on pppm_pkg and pulse_period_power_meter.
`timescale 1ns / 1ps

module pulse_period_power_meter_tb;
   import pppm_pkg::*;

   localparam action_type  ACT_UNUSED     = 2'd3;
   localparam logic        MODE_CURRENT   = 1'b0;
   localparam int unsigned SETTLE_CYCLES  = 200;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SEGMENT_ITEMS  = 148;

   typedef struct packed {
      logic [DATA_W-1:0] current_value;
      logic [DATA_W-1:0] voltage_value;
      logic [DATA_W-1:0] active_power;
      logic [DATA_W-1:0] apparent_power;
      logic [PF_W-1:0]   power_factor;
   } reading_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   action_type            req_action    = ACT_POWER;
   logic [DATA_W-1:0]     req_timestamp = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [DATA_W-1:0]     rsp_current_value;
   logic [DATA_W-1:0]     rsp_voltage_value;
   logic [DATA_W-1:0]     rsp_active_power;
   logic [DATA_W-1:0]     rsp_apparent_power;
   logic [PF_W-1:0]       rsp_power_factor;
   logic                  csr_write     = 1'b0;
   csr_idx_type           csr_index     = REG_CUR_MULT;
   logic [DATA_W-1:0]     csr_wdata     = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned error_count   = 0;
   int unsigned idle_cycles   = 0;

   reading_type pending_readings[$];

   // meter model: registers and channel state
   logic [DATA_W-1:0]   cfg_current_mult = '0;
   logic [DATA_W-1:0]   cfg_voltage_mult = '0;
   logic [DATA_W-1:0]   cfg_power_mult   = '0;
   logic                cfg_shared_mode  = MODE_RESET;
   logic [PERIOD_W-1:0] cfg_timeout      = TIMEOUT_RESET;
   logic [DATA_W-1:0]   power_edge_us    = '0;
   logic [DATA_W-1:0]   current_edge_us  = '0;
   logic [DATA_W-1:0]   voltage_edge_us  = '0;
   logic [PERIOD_W-1:0] power_period_us   = '0;
   logic [PERIOD_W-1:0] current_period_us = '0;
   logic [PERIOD_W-1:0] voltage_period_us = '0;
   logic [DATA_W-1:0]   time_base = '0;

   pulse_period_power_meter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_timestamp      (req_timestamp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_current_value  (rsp_current_value),
      .rsp_voltage_value  (rsp_voltage_value),
      .rsp_active_power   (rsp_active_power),
      .rsp_apparent_power (rsp_apparent_power),
      .rsp_power_factor   (rsp_power_factor),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic logic [PERIOD_W-1:0] capture_period(input logic [DATA_W-1:0] now,
                                                          input logic [DATA_W-1:0] last);
      logic [DATA_W-1:0] delta;
      delta = now - last;
      if (delta[DATA_W-1] || delta > {1'b0, cfg_timeout})
         return '0;
      return delta[PERIOD_W-1:0];
   endfunction

   task automatic apply_event(input action_type act, input logic [DATA_W-1:0] stamp);
      reading_type       r;
      logic [63:0]       product;
      logic [DVD_W-1:0]  ratio;
      case (act)
         ACT_POWER: begin
            power_period_us = capture_period(stamp, power_edge_us);
            power_edge_us   = stamp;
         end
         ACT_SHARED: begin
            if (cfg_shared_mode == MODE_CURRENT) begin
               current_period_us = capture_period(stamp, current_edge_us);
               current_edge_us   = stamp;
            end else begin
               voltage_period_us = capture_period(stamp, voltage_edge_us);
               voltage_edge_us   = stamp;
            end
         end
         ACT_READ: begin
            r.current_value = (power_period_us != '0 && current_period_us != '0) ?
                              cfg_current_mult / {1'b0, current_period_us} : '0;
            r.voltage_value = (voltage_period_us != '0) ?
                              cfg_voltage_mult / {1'b0, voltage_period_us} : '0;
            r.active_power  = (power_period_us != '0) ?
                              cfg_power_mult / {1'b0, power_period_us} : '0;
            product = 64'(r.voltage_value) * 64'(r.current_value);
            r.apparent_power = (product > 64'hFFFF_FFFF) ? '1 : product[DATA_W-1:0];
            if (r.active_power > r.apparent_power) begin
               r.power_factor = PF_ONE;
            end else if (r.apparent_power == '0) begin
               r.power_factor = '0;
            end else begin
               ratio = {r.active_power, {FRAC_W{1'b0}}} / DVD_W'(r.apparent_power);
               r.power_factor = ratio[PF_W-1:0];
            end
            power_period_us   = '0;
            current_period_us = '0;
            voltage_period_us = '0;
            pending_readings.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] actual);
      if (actual !== want) begin
         $error("%s expected %0d actual %0d", name, want, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("reading transaction with none expected");
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            compare_field("current_value", want.current_value, rsp_current_value);
            compare_field("voltage_value", want.voltage_value, rsp_voltage_value);
            compare_field("active_power", want.active_power, rsp_active_power);
            compare_field("apparent_power", want.apparent_power, rsp_apparent_power);
            compare_field("power_factor", DATA_W'(want.power_factor),
                          DATA_W'(rsp_power_factor));
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_item(input action_type act, input logic [DATA_W-1:0] stamp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_timestamp <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_event(act, stamp);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      case (idx)
         REG_CUR_MULT:  cfg_current_mult = data;
         REG_VOLT_MULT: cfg_voltage_mult = data;
         REG_POW_MULT:  cfg_power_mult   = data;
         REG_MODE:      cfg_shared_mode  = data[0];
         REG_TIMEOUT:   cfg_timeout      = data[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   // block must be idle; a stray index past the last register is written too
   task automatic program_registers(input logic [DATA_W-1:0] cur_mult,
                                    input logic [DATA_W-1:0] volt_mult,
                                    input logic [DATA_W-1:0] pow_mult,
                                    input logic [DATA_W-1:0] mode_word,
                                    input logic [DATA_W-1:0] timeout_word);
      drain_results();
      write_register(REG_CUR_MULT, cur_mult);
      write_register(REG_VOLT_MULT, volt_mult);
      write_register(REG_POW_MULT, pow_mult);
      write_register(REG_MODE, mode_word);
      write_register(REG_TIMEOUT, timeout_word);
      write_register(csr_idx_type'(REG_TIMEOUT + 1 + $urandom_range(0, 2)), $urandom);
      csr_write <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_multiplier();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_timeout_word();
      logic [PERIOD_W-1:0] limit;
      logic                top;
      top = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0:       limit = '0;
         1:       limit = '1;
         2:       limit = TIMEOUT_RESET;
         3:       limit = PERIOD_W'($urandom_range(1, 64));
         default: limit = PERIOD_W'($urandom_range(100, 100000));
      endcase
      return {top, limit};
   endfunction

   // mostly periods inside the timeout, some at its edge, some wild or zero
   function automatic logic [DATA_W-1:0] next_step();
      int unsigned       pick;
      logic [DATA_W-1:0] span;
      pick = $urandom_range(0, 99);
      if (cfg_timeout == '0)
         span = 1;
      else if (cfg_timeout < 4000)
         span = {1'b0, cfg_timeout};
      else
         span = 4000;
      if (pick < 70)
         return $urandom_range(1, span);
      if (pick < 80)
         return {1'b0, cfg_timeout} + $urandom_range(0, 2) - 1;
      if (pick < 90)
         return $urandom;
      return '0;
   endfunction

   task automatic test_reset_state();
      send_item(ACT_READ, 32'hFFFF_FFFF);
      send_item(ACT_UNUSED, 32'h0);
      send_item(ACT_POWER, 32'd500);
      send_item(ACT_SHARED, 32'd800);
      send_item(ACT_READ, 32'h0);
   endtask

   task automatic test_period_limits();
      program_registers('1, '1, '1, 32'(MODE_VOLTAGE), {1'b1, TIMEOUT_RESET});
      send_item(ACT_POWER, 32'd2000500);
      send_item(ACT_SHARED, 32'd2000801);
      send_item(ACT_READ, 32'h5555_5555);
      send_item(ACT_POWER, 32'd100);
      send_item(ACT_SHARED, 32'd2000802);
      send_item(ACT_READ, 32'hAAAA_AAAA);
      send_item(ACT_POWER, 32'hFFFF_FFF0);
      send_item(ACT_POWER, 32'h0000_0010);
      send_item(ACT_READ, 32'h0);
   endtask

   // voltage period set, then mode flipped so both channels hold periods
   task automatic test_saturation();
      program_registers('1, '1, '0, 32'(MODE_VOLTAGE), {1'b0, 31'h7FFF_FFFF});
      send_item(ACT_SHARED, 32'h0000_1000);
      send_item(ACT_SHARED, 32'h0000_1001);
      program_registers('1, '1, '0, {31'h7FFF_FFFF, MODE_CURRENT}, {1'b0, 31'h7FFF_FFFF});
      send_item(ACT_SHARED, 32'h0000_2000);
      send_item(ACT_SHARED, 32'h0000_2002);
      send_item(ACT_POWER, 32'h8000_0010);
      send_item(ACT_POWER, 32'h8000_0011);
      send_item(ACT_READ, 32'h0);
      send_item(ACT_SHARED, 32'h0000_2005);
      send_item(ACT_READ, 32'hFFFF_FFFF);
   endtask

   task automatic run_random_segment(input int unsigned n_items);
      int unsigned sent;
      int unsigned burst;
      action_type  act;
      program_registers(pick_multiplier(), pick_multiplier(), pick_multiplier(), $urandom,
                        pick_timeout_word());
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 10) begin
            act = action_type'($urandom_range(0, 3));
            send_item(act, $urandom);
            if (act != ACT_UNUSED)
               sent++;
         end else begin
            burst = $urandom_range(1, 6);
            repeat (burst) begin
               time_base += next_step();
               send_item($urandom_range(0, 1) ? ACT_POWER : ACT_SHARED, time_base);
            end
            sent += burst;
            if ($urandom_range(0, 99) < 85) begin
               send_item(ACT_READ, $urandom);
               sent++;
            end
         end
      end
   endtask

   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
      drain_results();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (3) run_random_segment(SEGMENT_ITEMS);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      time_base = $urandom;
      test_reset_state();
      test_period_limits();
      test_saturation();
      test_random_traffic(25, 84);
      test_random_traffic(84, 25);
      test_random_traffic(0, 0);
      drain_results();
      if (error_count == 0 && pending_readings.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
